@@ hdl/sfhc_pkg.sv @@
//------------------------------------------------------------------------------
// Split-flap stepper homing controller package
// Shared types, register indexes, reset values and the coil pattern function.
//------------------------------------------------------------------------------
package sfhc_pkg;

    typedef enum logic [1:0]
    {
        CMD_TICK,
        CMD_TARGET,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [2:0]  unit;
        logic [7:0]  sensor;
        logic [5:0]  flap;
        logic [11:0] offset;
    } cmd_t;

    typedef struct packed
    {
        logic [2:0] unit;
        logic [7:0] drive;
        logic       reached;
        logic [1:0] home_state;
    } result_t;

    typedef struct packed
    {
        logic [11:0] steps_per_rev;
        logic [5:0]  num_flaps;
        logic [7:0]  home_threshold;
        logic [9:0]  home_tolerance;
        logic [14:0] accel_start;
        logic [14:0] accel_count_step;
        logic [14:0] accel_period_step;
        logic [10:0] control;
    } cfg_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_DIVQ,
        BK_DIVR,
        BK_DONE
    } back_state_t;

    localparam logic [2:0] REG_STEPS_PER_REV     = 3'd0;
    localparam logic [2:0] REG_NUM_FLAPS         = 3'd1;
    localparam logic [2:0] REG_HOME_THRESHOLD    = 3'd2;
    localparam logic [2:0] REG_HOME_TOLERANCE    = 3'd3;
    localparam logic [2:0] REG_ACCEL_START       = 3'd4;
    localparam logic [2:0] REG_ACCEL_COUNT_STEP  = 3'd5;
    localparam logic [2:0] REG_ACCEL_PERIOD_STEP = 3'd6;
    localparam logic [2:0] REG_CONTROL           = 3'd7;

    localparam logic [1:0] HOME_WAIT     = 2'd0;
    localparam logic [1:0] HOME_SEEN_OFF = 2'd1;
    localparam logic [1:0] HOME_LOCKED   = 2'd2;

    localparam int CTL_ACCEL      = 0;
    localparam int CTL_HALF_STEP  = 1;
    localparam int CTL_ACTIVE_LOW = 2;

    localparam logic [11:0] RST_STEPS_PER_REV     = 12'd2048;
    localparam logic [5:0]  RST_NUM_FLAPS         = 6'd40;
    localparam logic [7:0]  RST_HOME_THRESHOLD    = 8'd128;
    localparam logic [9:0]  RST_HOME_TOLERANCE    = 10'd50;
    localparam logic [14:0] RST_ACCEL_START       = 15'd8;
    localparam logic [14:0] RST_ACCEL_COUNT_STEP  = 15'd1;
    localparam logic [14:0] RST_ACCEL_PERIOD_STEP = 15'd1;
    localparam logic [10:0] RST_CONTROL           = 11'd3;
    localparam logic [7:0]  RST_COIL              = 8'h01;

    localparam logic signed [13:0] POS_MAX   = 14'sd8191;
    localparam logic [4:0]         DIV_STEPS = 5'd19;

    function automatic logic [7:0] pattern_of(input logic [2:0] i);
        logic [3:0] a;
        a = {1'b0, i} + 4'd1;
        return (8'd1 << a[2:1]) | (8'd1 << i[2:1]);
    endfunction

endpackage

@@ hdl/sfhc_front.sv @@
//------------------------------------------------------------------------------
// Split-flap controller front end
// Takes requests into a two-entry queue and sorts them by kind.
//------------------------------------------------------------------------------
module sfhc_front #(
    parameter int UNITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic            op,
    input  logic [2:0]      unit,
    input  logic [7:0]      sensor,
    input  logic [5:0]      target_flap,
    input  logic [11:0]     home_offset,
    output logic            cmd_valid,
    output sfhc_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);
    import sfhc_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       new_cmd;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        new_cmd.unit   = unit;
        new_cmd.sensor = sensor;
        new_cmd.flap   = target_flap;
        new_cmd.offset = home_offset;
        if ({1'b0, unit} >= 4'(UNITS))
        begin
            new_cmd.kind = CMD_BAD;
        end
        else if (op)
        begin
            new_cmd.kind = CMD_TARGET;
        end
        else
        begin
            new_cmd.kind = CMD_TICK;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ hdl/sfhc_back.sv @@
//------------------------------------------------------------------------------
// Split-flap controller back end
// Runs the per-unit homing and stepping logic, computes targets with a shared
// restoring divider, and holds results in a two-entry output queue.
//------------------------------------------------------------------------------
module sfhc_back #(
    parameter int UNITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sfhc_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  sfhc_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              res_valid,
    output sfhc_pkg::result_t res,
    input  logic              res_pop
);
    import sfhc_pkg::*;

    logic [1:0]         hp_reg   [UNITS];
    logic [2:0]         idx_reg  [UNITS];
    logic [7:0]         coil_reg [UNITS];
    logic               hsl_reg  [UNITS];
    logic signed [16:0] tc_reg   [UNITS];
    logic signed [16:0] pl_reg   [UNITS];
    logic signed [13:0] pos_reg  [UNITS];
    logic [11:0]        ts_reg   [UNITS];

    back_state_t state_reg, state_next;

    logic [18:0] num_reg;
    logic [12:0] rem_reg;
    logic [11:0] div_reg;
    logic [4:0]  cnt_reg;
    logic [2:0]  unit_reg;
    logic [11:0] off_reg;

    result_t    oq_reg [2];
    logic       owr_reg, ord_reg;
    logic [1:0] ocnt_reg;
    logic       out_room;
    logic       out_push;
    logic       out_pop;
    result_t    out_data;

    logic [1:0]         cur_hp;
    logic [2:0]         cur_idx;
    logic [7:0]         cur_coil;
    logic               cur_hsl;
    logic signed [16:0] cur_tc;
    logic signed [16:0] cur_pl;
    logic signed [13:0] cur_pos;
    logic [11:0]        cur_ts;

    logic               home;
    logic signed [14:0] win_hi;
    logic signed [14:0] win_lo;
    logic signed [14:0] pos_w;
    logic signed [13:0] pos_a;
    logic               rotate;
    logic               step;
    logic               pl_pos;
    logic [7:0]         rev_bits;
    logic [1:0]         hp_n;
    logic               hsl_n;
    logic [2:0]         idx_n;
    logic [7:0]         coil_n;
    logic signed [13:0] pos_n;
    logic signed [16:0] tc_n;
    logic signed [16:0] pl_n;

    logic [12:0] trial;
    logic        ge;
    logic [12:0] rem_step;
    logic [18:0] num_step;
    logic        last_step;
    logic [11:0] ts_new;

    logic tick_we;
    logic target_start;
    logic ts_we;

    // Current state of the addressed unit.
    always_comb
    begin
        cur_hp   = hp_reg[cmd.unit];
        cur_idx  = idx_reg[cmd.unit];
        cur_coil = coil_reg[cmd.unit];
        cur_hsl  = hsl_reg[cmd.unit];
        cur_tc   = tc_reg[cmd.unit];
        cur_pl   = pl_reg[cmd.unit];
        cur_pos  = pos_reg[cmd.unit];
        cur_ts   = ts_reg[cmd.unit];
    end

    // Tick update for one unit.
    always_comb
    begin
        home     = cmd.sensor < cfg.home_threshold;
        win_hi   = signed'({3'b0, cfg.steps_per_rev}) + signed'({5'b0, cfg.home_tolerance});
        win_lo   = signed'({3'b0, cfg.steps_per_rev}) - signed'({5'b0, cfg.home_tolerance});
        pos_w    = {cur_pos[13], cur_pos};
        rev_bits = cfg.control[10:3];
        hp_n     = cur_hp;
        hsl_n    = cur_hsl;
        pos_a    = cur_pos;
        rotate   = 1'b1;
        if (cur_hp != HOME_LOCKED)
        begin
            if (cur_hp == HOME_WAIT && !home)
            begin
                hp_n = HOME_SEEN_OFF;
            end
            else if (cur_hp == HOME_SEEN_OFF && home)
            begin
                hp_n   = HOME_LOCKED;
                pos_a  = 14'sd0;
                rotate = (cur_ts != 12'd0);
            end
        end
        else
        begin
            if (home && !cur_hsl && pos_w >= win_lo && pos_w <= win_hi)
            begin
                pos_a = 14'sd0;
            end
            if ({pos_a[13], pos_a} > win_hi)
            begin
                hp_n = HOME_WAIT;
            end
            hsl_n  = home;
            rotate = (pos_a != signed'({2'b0, cur_ts}));
        end

        step   = (cur_tc <= 17'sd0) || !cfg.control[CTL_ACCEL];
        pl_pos = (cur_pl > 17'sd0);
        idx_n  = cur_idx;
        coil_n = cur_coil;
        pos_n  = pos_a;
        tc_n   = cur_tc;
        pl_n   = cur_pl;
        if (rotate)
        begin
            if (step)
            begin
                if (pl_pos)
                begin
                    tc_n = cur_pl;
                end
                if (!rev_bits[cmd.unit])
                begin
                    if (cfg.control[CTL_HALF_STEP])
                    begin
                        idx_n = cur_idx + 3'd1;
                    end
                    else
                    begin
                        idx_n = (cur_idx == 3'd6) ? 3'd0 : cur_idx + 3'd2;
                    end
                end
                else
                begin
                    if (cfg.control[CTL_HALF_STEP])
                    begin
                        idx_n = cur_idx - 3'd1;
                    end
                    else
                    begin
                        idx_n = (cur_idx == 3'd0) ? 3'd6 : cur_idx - 3'd2;
                    end
                end
                coil_n = pattern_of(idx_n) ^ {8{cfg.control[CTL_ACTIVE_LOW]}};
                if (pos_a < POS_MAX)
                begin
                    pos_n = pos_a + 14'sd1;
                end
            end
            if (pl_pos)
            begin
                tc_n = tc_n - signed'({2'b0, cfg.accel_count_step});
                pl_n = cur_pl - signed'({2'b0, cfg.accel_period_step});
            end
        end
        else
        begin
            coil_n = {8{cfg.control[CTL_ACTIVE_LOW]}};
            tc_n   = signed'({2'b0, cfg.accel_start});
            pl_n   = signed'({2'b0, cfg.accel_start});
        end
    end

    // One restoring divider step.
    always_comb
    begin
        trial     = {rem_reg[11:0], num_reg[18]};
        ge        = trial >= {1'b0, div_reg};
        rem_step  = ge ? trial - {1'b0, div_reg} : trial;
        num_step  = {num_reg[17:0], ge};
        last_step = (cnt_reg == DIV_STEPS - 5'd1);
        ts_new    = (cfg.steps_per_rev == 12'd0) ? 12'd0 : rem_reg[11:0];
    end

    assign out_room  = (ocnt_reg != 2'd2);
    assign res_valid = (ocnt_reg != 2'd0);
    assign res       = oq_reg[ord_reg];
    assign out_pop   = res_pop && res_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_room && cmd.kind == CMD_TARGET)
                begin
                    state_next = BK_DIVQ;
                end
            end
            BK_DIVQ:
            begin
                if (last_step)
                begin
                    state_next = BK_DIVR;
                end
            end
            BK_DIVR:
            begin
                if (last_step)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_room)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop      = 1'b0;
        out_push     = 1'b0;
        tick_we      = 1'b0;
        target_start = 1'b0;
        ts_we        = 1'b0;
        out_data     = '0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop       = cmd_valid && out_room;
                out_data.unit = cmd.unit;
                case (cmd.kind)
                    CMD_TICK:
                    begin
                        out_push            = cmd_pop;
                        tick_we             = cmd_pop;
                        out_data.drive      = {coil_n[5:0], 2'b00};
                        out_data.reached    = (hp_n == HOME_LOCKED) &&
                                              (pos_n == signed'({2'b0, cur_ts}));
                        out_data.home_state = hp_n;
                    end
                    CMD_TARGET:
                    begin
                        target_start = cmd_pop;
                    end
                    default:
                    begin
                        out_push = cmd_pop;
                    end
                endcase
            end
            BK_DONE:
            begin
                out_push            = out_room;
                ts_we               = out_room;
                out_data.unit       = unit_reg;
                out_data.drive      = {coil_reg[unit_reg][5:0], 2'b00};
                out_data.reached    = (hp_reg[unit_reg] == HOME_LOCKED) &&
                                      (pos_reg[unit_reg] == signed'({2'b0, ts_new}));
                out_data.home_state = hp_reg[unit_reg];
            end
            default:
            begin
                out_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            owr_reg   <= 1'b0;
            ord_reg   <= 1'b0;
            ocnt_reg  <= 2'd0;
            for (int i = 0; i < UNITS; i++)
            begin
                hp_reg[i]   <= HOME_WAIT;
                idx_reg[i]  <= 3'd0;
                coil_reg[i] <= RST_COIL;
                hsl_reg[i]  <= 1'b0;
                tc_reg[i]   <= signed'({2'b0, RST_ACCEL_START});
                pl_reg[i]   <= signed'({2'b0, RST_ACCEL_START});
                pos_reg[i]  <= -14'sd1;
                ts_reg[i]   <= 12'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_push)
            begin
                owr_reg <= ~owr_reg;
            end
            if (out_pop)
            begin
                ord_reg <= ~ord_reg;
            end
            ocnt_reg <= ocnt_reg + {1'b0, out_push} - {1'b0, out_pop};
            if (tick_we)
            begin
                hp_reg[cmd.unit]   <= hp_n;
                idx_reg[cmd.unit]  <= idx_n;
                coil_reg[cmd.unit] <= coil_n;
                hsl_reg[cmd.unit]  <= hsl_n;
                tc_reg[cmd.unit]   <= tc_n;
                pl_reg[cmd.unit]   <= pl_n;
                pos_reg[cmd.unit]  <= pos_n;
            end
            if (ts_we)
            begin
                ts_reg[unit_reg] <= ts_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            oq_reg[owr_reg] <= out_data;
        end
        if (target_start)
        begin
            num_reg  <= {7'b0, cfg.steps_per_rev} * {13'b0, cmd.flap};
            div_reg  <= (cfg.num_flaps == 6'd0) ? 12'd1 : {6'b0, cfg.num_flaps};
            rem_reg  <= 13'd0;
            cnt_reg  <= 5'd0;
            unit_reg <= cmd.unit;
            off_reg  <= cmd.offset;
        end
        else if (state_reg == BK_DIVQ)
        begin
            if (last_step)
            begin
                num_reg <= {7'b0, off_reg} + num_step;
                rem_reg <= 13'd0;
                div_reg <= cfg.steps_per_rev;
                cnt_reg <= 5'd0;
            end
            else
            begin
                num_reg <= num_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
        else if (state_reg == BK_DIVR)
        begin
            num_reg <= num_step;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

endmodule

@@ hdl/split_flap_stepper_homing_controller_core.sv @@
//------------------------------------------------------------------------------
// Split-flap stepper homing controller
// Drives up to UNITS split-flap stepper motors with homing and acceleration.
//
// Requests enter through a queue port: push while full is low. Each request
// is a tick for one unit, carrying its home sensor byte, or a new target flap
// for one unit. Every request yields exactly one result, read through a queue
// port: the result is valid while empty is low and leaves on pop.
// A tick or a request for a missing unit is finished by the back end on
// acceptance, so its result shows in the cycle after acceptance, and ticks can
// be taken every cycle while the output queue has room. A set-target request
// runs two 19-step passes of the shared restoring divider; its result is then
// pushed when the output queue has room; no other request is taken meanwhile.
// Up to two requests wait in the front queue and two results in the output
// queue; a stalled reader fills the output queue and then holds back the
// back end and, in turn, the input.
// Reset puts every unit in the waiting-for-not-home phase at position -1 and
// loads the registers with their default values. The user must write registers
// over the APB port only while no request is in flight; nothing enforces this.
//------------------------------------------------------------------------------
module split_flap_stepper_homing_controller_core #(
    parameter int UNITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [2:0]  unit,
    input  logic [7:0]  sensor,
    input  logic [5:0]  target_flap,
    input  logic [11:0] home_offset,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  unit_out,
    output logic [7:0]  drive,
    output logic        reached,
    output logic [1:0]  home_state
);
    import sfhc_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    logic    res_valid;
    result_t res;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_rev     <= RST_STEPS_PER_REV;
            cfg_reg.num_flaps         <= RST_NUM_FLAPS;
            cfg_reg.home_threshold    <= RST_HOME_THRESHOLD;
            cfg_reg.home_tolerance    <= RST_HOME_TOLERANCE;
            cfg_reg.accel_start       <= RST_ACCEL_START;
            cfg_reg.accel_count_step  <= RST_ACCEL_COUNT_STEP;
            cfg_reg.accel_period_step <= RST_ACCEL_PERIOD_STEP;
            cfg_reg.control           <= RST_CONTROL;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_STEPS_PER_REV:     cfg_reg.steps_per_rev     <= pwdata[11:0];
                REG_NUM_FLAPS:         cfg_reg.num_flaps         <= pwdata[5:0];
                REG_HOME_THRESHOLD:    cfg_reg.home_threshold    <= pwdata[7:0];
                REG_HOME_TOLERANCE:    cfg_reg.home_tolerance    <= pwdata[9:0];
                REG_ACCEL_START:       cfg_reg.accel_start       <= pwdata[14:0];
                REG_ACCEL_COUNT_STEP:  cfg_reg.accel_count_step  <= pwdata[14:0];
                REG_ACCEL_PERIOD_STEP: cfg_reg.accel_period_step <= pwdata[14:0];
                REG_CONTROL:           cfg_reg.control           <= pwdata[10:0];
                default:               cfg_reg.control           <= cfg_reg.control;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_STEPS_PER_REV:     prdata = {20'd0, cfg_reg.steps_per_rev};
            REG_NUM_FLAPS:         prdata = {26'd0, cfg_reg.num_flaps};
            REG_HOME_THRESHOLD:    prdata = {24'd0, cfg_reg.home_threshold};
            REG_HOME_TOLERANCE:    prdata = {22'd0, cfg_reg.home_tolerance};
            REG_ACCEL_START:       prdata = {17'd0, cfg_reg.accel_start};
            REG_ACCEL_COUNT_STEP:  prdata = {17'd0, cfg_reg.accel_count_step};
            REG_ACCEL_PERIOD_STEP: prdata = {17'd0, cfg_reg.accel_period_step};
            REG_CONTROL:           prdata = {21'd0, cfg_reg.control};
            default:               prdata = 32'd0;
        endcase
    end

    sfhc_front #(
        .UNITS (UNITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .unit        (unit),
        .sensor      (sensor),
        .target_flap (target_flap),
        .home_offset (home_offset),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    sfhc_back #(
        .UNITS (UNITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty      = !res_valid;
    assign unit_out   = res.unit;
    assign drive      = res.drive;
    assign reached    = res.reached;
    assign home_state = res.home_state;

endmodule

@@ verif/split_flap_stepper_homing_controller_core_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Split-flap stepper homing controller checker
// Watches the register port and both queue ports, predicts every result from
// its own model of the homing, acceleration and stepping, and compares.
//------------------------------------------------------------------------------
module split_flap_stepper_homing_controller_core_checker
    import sfhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        push,
    input  logic        full,
    input  logic        op,
    input  logic [2:0]  unit,
    input  logic [7:0]  sensor,
    input  logic [5:0]  target_flap,
    input  logic [11:0] home_offset,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  unit_out,
    input  logic [7:0]  drive,
    input  logic        reached,
    input  logic [1:0]  home_state,
    output int          errors,
    output int          pending
);

    cfg_t       cfg;
    logic [1:0] homing [8];
    logic [2:0] step_idx [8];
    logic [7:0] coils [8];
    logic       home_last [8];
    int         tick_cnt [8];
    int         period [8];
    int         pos [8];
    int         target [8];
    result_t    drive_results[$];

    assign pending = drive_results.size();

    function automatic logic [7:0] coils_at(input int i);
        int p;
        p = (1 << (((i + 1) / 2) % 4)) | (1 << (i / 2));
        if (cfg.control[CTL_ACTIVE_LOW])
            p = ~p;
        return p[7:0];
    endfunction

    task automatic step_unit(input int u, input logic [7:0] s);
        bit home;
        bit rotate;
        int spr;
        int tol;
        int inc;
        int last;
        int idx;
        home = s < cfg.home_threshold;
        spr = cfg.steps_per_rev;
        tol = cfg.home_tolerance;
        if (homing[u] != HOME_LOCKED)
        begin
            rotate = 1;
            if (homing[u] == HOME_WAIT && !home)
                homing[u] = HOME_SEEN_OFF;
            else if (homing[u] == HOME_SEEN_OFF && home)
            begin
                homing[u] = HOME_LOCKED;
                pos[u] = 0;
                rotate = target[u] != 0;
            end
        end
        else
        begin
            if (home && !home_last[u] && pos[u] >= spr - tol && pos[u] <= spr + tol)
                pos[u] = 0;
            if (pos[u] > spr + tol)
                homing[u] = HOME_WAIT;
            home_last[u] = home;
            rotate = pos[u] != target[u];
        end
        if (rotate)
        begin
            if (tick_cnt[u] <= 0 || !cfg.control[CTL_ACCEL])
            begin
                inc = cfg.control[CTL_HALF_STEP] ? 1 : 2;
                last = 8 - inc;
                idx = step_idx[u];
                if (period[u] > 0)
                    tick_cnt[u] = period[u];
                if (!cfg.control[3 + u])
                    idx = (idx == last) ? 0 : idx + inc;
                else
                    idx = (idx == 0) ? last : idx + 8 - inc;
                step_idx[u] = idx[2:0];
                coils[u] = coils_at(idx & 7);
                if (pos[u] < POS_MAX)
                    pos[u]++;
            end
            if (period[u] > 0)
            begin
                tick_cnt[u] -= int'(cfg.accel_count_step);
                period[u] -= int'(cfg.accel_period_step);
            end
        end
        else
        begin
            coils[u] = cfg.control[CTL_ACTIVE_LOW] ? 8'hFF : 8'h00;
            tick_cnt[u] = cfg.accel_start;
            period[u] = cfg.accel_start;
        end
    endtask

    task automatic predict_request();
        int u;
        int nf;
        int q;
        result_t r;
        u = unit;
        if (op == CMD_TARGET[0])
        begin
            nf = (cfg.num_flaps != 0) ? cfg.num_flaps : 1;
            q = (int'(cfg.steps_per_rev) * int'(target_flap)) / nf;
            target[u] = (cfg.steps_per_rev != 0) ? (int'(home_offset) + q) % cfg.steps_per_rev : 0;
        end
        else
            step_unit(u, sensor);
        r.unit = unit;
        r.drive = {coils[u][5:0], 2'b00};
        r.reached = homing[u] == HOME_LOCKED && pos[u] == target[u];
        r.home_state = homing[u];
        drive_results.push_back(r);
    endtask

    task automatic check_result();
        result_t e;
        if (drive_results.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: result with none expected: unit %0d drive %h", $realtime,
                         unit_out, drive);
        end
        else
        begin
            e = drive_results.pop_front();
            if (e.unit !== unit_out || e.drive !== drive || e.reached !== reached
                || e.home_state !== home_state)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: expected unit %0d drive %h reached %b home %0d, got %0d %h %b %0d",
                             $realtime, e.unit, e.drive, e.reached, e.home_state,
                             unit_out, drive, reached, home_state);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            drive_results.delete();
            cfg = '{RST_STEPS_PER_REV, RST_NUM_FLAPS, RST_HOME_THRESHOLD,
                    RST_HOME_TOLERANCE, RST_ACCEL_START, RST_ACCEL_COUNT_STEP,
                    RST_ACCEL_PERIOD_STEP, RST_CONTROL};
            for (int u = 0; u < 8; u++)
            begin
                homing[u] = HOME_WAIT;
                step_idx[u] = 0;
                coils[u] = 8'h01;
                home_last[u] = 0;
                tick_cnt[u] = RST_ACCEL_START;
                period[u] = RST_ACCEL_START;
                pos[u] = -1;
                target[u] = 0;
            end
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                predict_request();
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_STEPS_PER_REV:     cfg.steps_per_rev = pwdata[11:0];
                    REG_NUM_FLAPS:         cfg.num_flaps = pwdata[5:0];
                    REG_HOME_THRESHOLD:    cfg.home_threshold = pwdata[7:0];
                    REG_HOME_TOLERANCE:    cfg.home_tolerance = pwdata[9:0];
                    REG_ACCEL_START:       cfg.accel_start = pwdata[14:0];
                    REG_ACCEL_COUNT_STEP:  cfg.accel_count_step = pwdata[14:0];
                    REG_ACCEL_PERIOD_STEP: cfg.accel_period_step = pwdata[14:0];
                    REG_CONTROL:           cfg.control = pwdata[10:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ verif/split_flap_stepper_homing_controller_core_test.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Split-flap stepper homing controller testbench
// Drives ticks and target requests through the queue ports with random gaps
// and reader stalls, under several register settings, and lets the checker
// judge every result.
//------------------------------------------------------------------------------
module split_flap_stepper_homing_controller_core_test;
    import sfhc_pkg::*;

    localparam int LIMIT = 2000000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 0;
    logic        full;
    logic        op = 0;
    logic [2:0]  unit = 0;
    logic [7:0]  sensor = 0;
    logic [5:0]  target_flap = 0;
    logic [11:0] home_offset = 0;
    logic        empty;
    logic        pop = 0;
    logic [2:0]  unit_out;
    logic [7:0]  drive;
    logic        reached;
    logic [1:0]  home_state;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          calm = 0;
    int          spr_now = RST_STEPS_PER_REV;
    int          thr_now = RST_HOME_THRESHOLD;
    int          drum_ticks [8];

    split_flap_stepper_homing_controller_core u_dut (.*);

    split_flap_stepper_homing_controller_core_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= calm || $urandom_range(99) >= 15;

    task automatic send(input bit is_target, input int u, input int s, input int f, input int o);
        while (!calm && $urandom_range(99) < 15)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        op <= is_target ? CMD_TARGET[0] : CMD_TICK[0];
        unit <= 3'(u);
        sensor <= 8'(s);
        target_flap <= 6'(f);
        home_offset <= 12'(o);
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        push <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic configure(input int spr, input int nf, input int thr, input int tol,
                             input int as, input int acs, input int aps, input int ctl);
        drain();
        write_reg(REG_STEPS_PER_REV, spr);
        write_reg(REG_NUM_FLAPS, nf);
        write_reg(REG_HOME_THRESHOLD, thr);
        write_reg(REG_HOME_TOLERANCE, tol);
        write_reg(REG_ACCEL_START, as);
        write_reg(REG_ACCEL_COUNT_STEP, acs);
        write_reg(REG_ACCEL_PERIOD_STEP, aps);
        write_reg(REG_CONTROL, ctl);
        @(negedge clk);
        spr_now = spr;
        thr_now = thr;
    endtask

    task automatic random_requests(input int n);
        int u;
        int s;
        bit home;
        for (int k = 0; k < n; k++)
        begin
            u = $urandom_range(7);
            if ($urandom_range(99) < 10)
                send(1, u, $urandom, $urandom_range(63), $urandom_range(4095));
            else
            begin
                drum_ticks[u]++;
                home = (drum_ticks[u] % (spr_now + 1)) < 2 ? $urandom_range(9) < 8
                                                              : $urandom_range(99) < 5;
                if (home && thr_now > 0)
                    s = $urandom_range(thr_now - 1);
                else
                    s = $urandom_range(255, thr_now > 255 ? 255 : thr_now);
                send(0, u, s, $urandom_range(63), $urandom_range(4095));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        send(1, 0, 0, 0, 0);
        send(1, 1, 255, 63, 4095);
        send(1, 2, 0, 20, 100);
        send(0, 0, 255, 0, 0);
        send(0, 0, 0, 0, 0);
        send(0, 0, 255, 0, 0);
        send(0, 1, 200, 0, 0);
        send(0, 1, 127, 0, 0);
        send(0, 1, 128, 0, 0);
        send(0, 2, 128, 0, 0);
        send(0, 2, 0, 0, 0);
        for (int k = 0; k < 10; k++)
            send(0, 1 + k % 2, 255, 0, 0);
        send(0, 7, 255, 63, 4095);
        send(1, 7, 0, 63, 4095);

        calm = 1;
        random_requests(60);
        calm = 0;
        random_requests(100);

        configure(16, 4, 100, 3, 3, 1, 1, 11'h0AB);
        random_requests(150);

        configure(4095, 63, 255, 1023, 32767, 32767, 32767, 11'h7FF);
        random_requests(100);

        configure(0, 0, 0, 0, 0, 0, 0, 0);
        random_requests(40);

        configure(4095, 63, 0, 1023, 0, 0, 0, 0);
        calm = 1;
        for (int k = 0; k < 40; k++)
            send(0, 3, $urandom, 0, 0);
        calm = 0;

        configure(24, 12, 128, 2, 5, 2, 1, 11'h556);
        random_requests(110);

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
